### hw/rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int HANDLE_W     = 8;
    localparam int PRIO_W       = 8;
    localparam int COUNT_W      = 5;

    // Operation codes carried in the input tuser bit.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // What one cell shows to its neighbours.
    typedef struct packed {
        logic                occ;
        logic                ge;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } t_link;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } t_op;

endpackage

### hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, count and output register.
//
//  Channel | Direction | tdata (low bit first)                         | tuser
//  s       | in        | item_handle[7:0], item_priority[15:8]         | cmd
//  m       | out       | popped_handle[7:0], popped_priority[15:8],    | -
//          |           | popped_valid[16], push_rejected[17],          |
//          |           | entry_count[22:18], zero[23]                  |
//
// The whole chain of cells moves in the cycle a word is accepted, so a new
// word can be taken on every clock edge while the output is not stalled.
// The result appears in the cycle after acceptance and sits in an output
// register; a new word is accepted whenever that register is empty or is
// being emptied in the same cycle, so a stalled output stops the input.
// Reset (synchronous, active low) empties the queue and the output register
// at once; no clearing pass is needed since each cell keeps its own valid bit.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // item_handle, item_priority
    input  logic        i_s_tuser,   // cmd
    // Result word stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // popped_handle, popped_priority, popped_valid,
                                     // push_rejected, entry_count, zero pad
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_link w_link [CAPACITY];
    t_link w_head_left;
    t_link w_tail_right;
    t_op   w_op;

    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_is_pop;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [31:0]         w_count_ext;

    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [PRIO_W-1:0]   r_out_prio;
    logic                r_out_popped;
    logic                r_out_rejected;
    logic [COUNT_W-1:0]  r_out_count;

    // The input side is free whenever the output register can take a result.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_pop   = (i_s_tuser == CMD_POP);

    // Occupancy is contiguous from the head, so the end cells tell full and empty.
    assign w_full  = w_link[CAPACITY-1].occ;
    assign w_empty = !w_link[0].occ;

    // A push to a full queue and a pop from an empty one leave the chain alone.
    assign w_op = '{push:   w_accept && !w_is_pop && !w_full,
                    pop:    w_accept && w_is_pop && !w_empty,
                    handle: i_s_tdata[7:0],
                    prio:   i_s_tdata[15:8]};

    // The head sees a held entry that always outranks a new one, so a push
    // into an empty queue or ahead of everything lands in the first cell.
    assign w_head_left  = '{occ: 1'b1, ge: 1'b1, handle: '0, prio: '0};
    assign w_tail_right = '{occ: 1'b0, ge: 1'b0, handle: '0, prio: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_left  ((g == 0) ? w_head_left : w_link[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? w_tail_right
                                          : w_link[(g == CAPACITY - 1) ? g : g + 1]),
            .o_link  (w_link[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_op.push) begin
            n_count = r_count + CW'(1);
        end else if (w_op.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // The reported count is the count after this operation, masked to five bits.
    assign w_count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_handle   <= w_op.pop ? w_link[0].handle : '0;
            r_out_prio     <= w_op.pop ? w_link[0].prio : '0;
            r_out_popped   <= w_op.pop;
            r_out_rejected <= !w_is_pop && w_full;
            r_out_count    <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_rejected, r_out_popped,
                         r_out_prio, r_out_handle};

    // A result is never both a returned entry and a rejected push.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(r_out_popped && r_out_rejected))
        else $error("result marks both a popped entry and a rejected push");

    // The count never goes beyond the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    // The head cell is occupied exactly when the count is non-zero.
    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[0].occ == (r_count != '0))
        else $error("head occupancy disagrees with held count");

    // An accepted push into a queue with room grows the count by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_pop && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");

endmodule

### hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts towards either neighbour.
module spq_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_op   i_op,
    input  spq_pkg::t_link i_left,
    input  spq_pkg::t_link i_right,
    output spq_pkg::t_link o_link
);
    import spq_pkg::*;

    logic                r_occ;
    logic                n_occ;
    logic [HANDLE_W-1:0] r_handle;
    logic [HANDLE_W-1:0] n_handle;
    logic [PRIO_W-1:0]   r_prio;
    logic [PRIO_W-1:0]   n_prio;
    logic                w_ge;

    // This entry stays ahead of the new one when it is held and not lower.
    assign w_ge = r_occ && (r_prio >= i_op.prio);

    assign o_link = '{occ: r_occ, ge: w_ge, handle: r_handle, prio: r_prio};

    always_comb begin
        n_occ    = r_occ;
        n_handle = r_handle;
        n_prio   = r_prio;
        if (i_op.push) begin
            n_occ = r_occ | i_left.occ;
            if (!w_ge) begin
                if (i_left.ge) begin
                    n_handle = i_op.handle;
                    n_prio   = i_op.prio;
                end else begin
                    n_handle = i_left.handle;
                    n_prio   = i_left.prio;
                end
            end
        end else if (i_op.pop) begin
            n_occ    = i_right.occ;
            n_handle = i_right.handle;
            n_prio   = i_right.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_prio   <= n_prio;
    end

endmodule

### bench/tb_top.sv
// Self-checking testbench of the sorted priority queue: directed table, random traffic, checking.
module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int RANDOM_WORDS = 1150;
    localparam int LONG_HOLD    = 200;   // receiver stall long enough to back up the input
    localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // One result word as the block presents it.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        logic                valid;
        logic                rejected;
        logic [COUNT_W-1:0]  count;
    } t_pop_result;

    // One row of the directed table. Rows with a typed result are checked against it.
    typedef struct {
        logic                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        int                  reps;
        bit                  typed;
        t_pop_result         want;
    } t_stim_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;    // item_handle, item_priority
    logic        i_s_tuser  = 1'b0;  // cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;          // popped_handle, popped_priority, popped_valid,
                                     // push_rejected, entry_count, zero pad

    // Our own copy of the queue contents, head in slot 0.
    logic [HANDLE_W-1:0] q_handle [CAPACITY];
    logic [PRIO_W-1:0]   q_prio   [CAPACITY];
    int                  held = 0;

    t_pop_result pending_results [$];
    t_stim_row   stim_table [11];
    int          n_faults      = 0;
    int          n_results     = 0;
    int          idle_cycles   = 0;
    bit          long_hold_req = 1'b0;

    sorted_priority_queue_top #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Applies one operation to the local queue and returns the word it should produce.
    // A push lands behind every entry of greater or equal priority, so equal
    // priorities leave in arrival order.
    function automatic t_pop_result next_queue_outcome(input logic cmd,
                                                       input logic [HANDLE_W-1:0] h,
                                                       input logic [PRIO_W-1:0] p);
        t_pop_result r;
        int          slot;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (held >= CAPACITY) begin
                r.rejected = 1'b1;
            end else begin
                slot = held;
                while (slot > 0 && q_prio[slot-1] < p) begin
                    q_handle[slot] = q_handle[slot-1];
                    q_prio[slot]   = q_prio[slot-1];
                    slot--;
                end
                q_handle[slot] = h;
                q_prio[slot]   = p;
                held++;
            end
        end else if (held != 0) begin
            r.handle = q_handle[0];
            r.prio   = q_prio[0];
            r.valid  = 1'b1;
            for (int i = 0; i + 1 < held; i++) begin
                q_handle[i] = q_handle[i+1];
                q_prio[i]   = q_prio[i+1];
            end
            held--;
        end
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none at all in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one word and waits for the handshake; the expectation is queued on acceptance.
    task automatic send_word(input logic cmd, input logic [HANDLE_W-1:0] h,
                             input logic [PRIO_W-1:0] p, input bit typed,
                             input t_pop_result typed_want);
        t_pop_result outcome;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p, h};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        outcome = next_queue_outcome(cmd, h, p);
        pending_results.push_back(typed ? typed_want : outcome);
    endtask

    // Drops valid for a while; with drain set it also waits until every result is back.
    task automatic sender_pause(input int cycles, input bit drain);
        if (drain && cycles == 0) cycles = 1;
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
            if (drain) while (pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            n_faults++;
            if (n_faults <= MAX_REPORTS)
                $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                         name, n_results, want, got);
        end
    endtask

    // Sender: reset, directed table, then random segments of varying character.
    initial begin : tx_side
        t_pop_result none;
        logic                cmd;
        logic [HANDLE_W-1:0] h;
        logic [PRIO_W-1:0]   p, base;
        int                  seg, seg_len, push_pct, n_sent;
        bit                  calm, narrow, drain;
        none = '0;
        stim_table = '{
            // Pop on an empty queue gives an all-zero word.
            '{CMD_POP,  8'h00, 8'h00, 1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 5'd0}},
            '{CMD_PUSH, 8'h00, 8'h00, 1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 5'd1}},
            '{CMD_PUSH, 8'hFF, 8'hFF, 1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 5'd2}},
            // Three equal priorities must come out in arrival order.
            '{CMD_PUSH, 8'h5A, 8'h80, 1,  1'b0, none},
            '{CMD_PUSH, 8'hA5, 8'h80, 1,  1'b0, none},
            '{CMD_PUSH, 8'h11, 8'h80, 1,  1'b0, none},
            '{CMD_POP,  8'h00, 8'h00, 1,  1'b1, '{8'hFF, 8'hFF, 1'b1, 1'b0, 5'd4}},
            // Fill to capacity with scattered priorities.
            '{CMD_PUSH, 8'h30, 8'h40, 12, 1'b0, none},
            // Pushes into a full queue are refused and leave it unchanged.
            '{CMD_PUSH, 8'hC3, 8'h3C, 1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 5'd16}},
            '{CMD_PUSH, 8'hFF, 8'hFF, 1,  1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 5'd16}},
            '{CMD_POP,  8'h00, 8'h00, 2,  1'b0, none}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[r]) begin
            for (int k = 0; k < stim_table[r].reps; k++) begin
                send_word(stim_table[r].cmd, stim_table[r].handle + HANDLE_W'(k),
                          stim_table[r].prio + PRIO_W'(k * 53), stim_table[r].typed,
                          stim_table[r].want);
                sender_pause(pick_gap(1'b0), 1'b0);
            end
        end

        // Each segment has its own push/pop balance so the queue swings between
        // empty and full; narrow segments crowd the priorities to force ties.
        n_sent = 0;
        seg    = 0;
        while (n_sent < RANDOM_WORDS) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = $urandom_range(0, 100);
            endcase
            narrow = 1'($urandom_range(0, 1));
            base   = PRIO_W'($urandom_range(0, 253));
            calm   = ($urandom_range(0, 3) == 0) || (seg == 2);
            // In the third segment the receiver holds off while we keep offering.
            if (seg == 2) long_hold_req = 1'b1;
            for (int i = 0; i < seg_len; i++) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                h   = HANDLE_W'($urandom);
                p   = narrow ? base + PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom);
                send_word(cmd, h, p, 1'b0, none);
                drain = (i == seg_len - 1) && (seg == 5 || $urandom_range(0, 7) == 0);
                sender_pause(pick_gap(calm), drain);
            end
            n_sent += seg_len;
            seg++;
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_faults == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: random ready pattern, calm stretches, and one long stall on request.
    initial begin : rx_side
        int lo, hi;
        bit calm;
        calm = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                lo = LONG_HOLD;
            end else begin
                lo = pick_gap(calm);
            end
            if ($urandom_range(0, 15) == 0) calm = !calm;
            if (lo > 0) begin
                i_m_tready <= 1'b0;
                repeat (lo) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            hi = $urandom_range(1, 8);
            repeat (hi) @(posedge i_clk);
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_pop_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                n_faults++;
                if (n_faults <= MAX_REPORTS)
                    $display("Unexpected result %0d: 0x%06h", n_results, o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                compare_field("popped_handle",   32'(want.handle),   32'(o_m_tdata[7:0]));
                compare_field("popped_priority", 32'(want.prio),     32'(o_m_tdata[15:8]));
                compare_field("popped_valid",    32'(want.valid),    32'(o_m_tdata[16]));
                compare_field("push_rejected",   32'(want.rejected), 32'(o_m_tdata[17]));
                compare_field("entry_count",     32'(want.count),    32'(o_m_tdata[22:18]));
                compare_field("pad bit",         32'd0,              32'(o_m_tdata[23]));
            end
            n_results++;
        end
    end

    // Watchdog: gives up after a long run of cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
